@@ rtl/core/lir_pkg.sv @@
// Shared types and constants for the linear interpolation resampler.
`default_nettype none

package lir_pkg;

   localparam int SampleWidth = 24;
   localparam int StepWidth   = 20;
   localparam int PhaseWidth  = 21;
   localparam int FracWidth   = 16;
   localparam int CountWidth  = 5;

   localparam logic [PhaseWidth-1:0] PhaseOne   = 21'h010000;
   localparam logic [StepWidth-1:0]  StepReset  = 20'h10000;
   localparam logic [CountWidth-1:0] MaxInterp  = 5'd16;

   // One queued input transaction.
   typedef struct packed {
      logic                          block_end;
      logic signed [SampleWidth-1:0] sample_right;
      logic signed [SampleWidth-1:0] sample_left;
   } lir_item_type;

endpackage

`default_nettype wire

@@ rtl/core/linear_interp_resampler_top.sv @@
// Top level of the stereo linear interpolation resampler.
`default_nettype none

// Stereo linear-interpolation sample rate converter. Each input transaction
// carries a left/right Q1.23 pair; the block emits every output whose read
// position (Q5.16, advancing by the Q4.16 rate_step written on the csr port)
// falls between the previous pair and this one, computed as
// prev + floor(frac * (cur - prev)) and truncated to 24 bits. The last input of a
// block (req_tlast) adds one exact copy of that pair flagged with rsp_tlast,
// and the next input reloads the position with one step. At most sixteen
// interpolated outputs are made per input. Inputs land in a short queue
// (QUEUE_DEPTH entries) while a single interpolation engine serves them one at
// a time: each interpolated output passes through the shared multiplier pair
// and then the adder that loads the output register, and the final copy of a
// block follows the last of them. Outputs stall only on rsp_tready. Write
// rate_step only while the block is idle; the write also clears the history
// pair.

module linear_interp_resampler_top
   import lir_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Configuration: rate_step, unsigned Q4.16.
   input  wire logic         csr_wr_en,
   input  wire logic [19:0]  csr_wr_data,
   // Input stream.
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [47:0]  req_tdata,   // [23:0] sample_left, [47:24] sample_right
   input  wire logic         req_tlast,   // block_end
   // Result stream.
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [47:0]       rsp_tdata,   // [23:0] out_left, [47:24] out_right
   output logic              rsp_tlast    // out_last
);

   lir_item_type  q_item;
   logic          q_valid;
   logic          q_pop;

   // Front: accept transactions into the queue.
   lir_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // Back: advance the read position and produce the outputs.
   lir_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

`default_nettype wire

@@ rtl/core/lir_front.sv @@
// Input side: unpack stream transactions into a short queue for the engine.
`default_nettype none

module lir_front
   import lir_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [47:0]  req_tdata,
   input  wire logic         req_tlast,
   output logic              q_valid,
   output lir_item_type      q_item,
   input  wire logic         q_pop
);

   localparam int PtrWidth = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);

   lir_item_type          queue_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   lir_item_type          item;
   logic                  push;
   logic                  pop;

   always_comb begin
      item.sample_left  = req_tdata[23:0];
      item.sample_right = req_tdata[47:24];
      item.block_end    = req_tlast;
   end

   assign req_tready = (count_ff != CntWidth'(QUEUE_DEPTH));
   assign q_valid    = (count_ff != '0);
   assign q_item     = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/lir_back.sv @@
// Interpolation engine: walks the read position and drives the output register.
`default_nettype none

module lir_back
   import lir_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [StepWidth-1:0]   csr_wr_data,
   input  wire logic                   q_valid,
   input  wire lir_item_type           q_item,
   output logic                        q_pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [47:0]                 rsp_tdata,
   output logic                        rsp_tlast
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EMIT,
      ST_LAST
   } state_type;

   state_type                      state_ff, state_in;
   logic [StepWidth-1:0]           step_ff, step_in;
   logic [PhaseWidth-1:0]          phase_ff, phase_in;
   logic [CountWidth-1:0]          n_ff, n_in;
   logic                           start_ff, start_in;
   logic signed [SampleWidth-1:0]  hist_l_ff, hist_l_in;
   logic signed [SampleWidth-1:0]  hist_r_ff, hist_r_in;
   lir_item_type                   cur_ff, cur_in;
   logic signed [41:0]             prod_l_ff, prod_l_in;
   logic signed [41:0]             prod_r_ff, prod_r_in;
   logic                           out_valid_ff, out_valid_in;
   logic [47:0]                    out_data_ff, out_data_in;
   logic                           out_last_ff, out_last_in;

   logic                           out_free;
   logic signed [24:0]             diff_l, diff_r;
   logic signed [16:0]             frac;
   logic signed [25:0]             sum_l, sum_r;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   assign diff_l = {cur_ff.sample_left[23], cur_ff.sample_left} - {hist_l_ff[23], hist_l_ff};
   assign diff_r = {cur_ff.sample_right[23], cur_ff.sample_right} - {hist_r_ff[23], hist_r_ff};
   assign frac   = $signed({1'b0, phase_ff[FracWidth-1:0]});
   // Arithmetic shift floors the scaled difference.
   assign sum_l  = {{2{hist_l_ff[23]}}, hist_l_ff} + prod_l_ff[41:16];
   assign sum_r  = {{2{hist_r_ff[23]}}, hist_r_ff} + prod_r_ff[41:16];

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      phase_in     = phase_ff;
      n_in         = n_ff;
      start_in     = start_ff;
      hist_l_in    = hist_l_ff;
      hist_r_in    = hist_r_ff;
      cur_in       = cur_ff;
      prod_l_in    = prod_l_ff;
      prod_r_in    = prod_r_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (csr_wr_en) begin
         step_in   = csr_wr_data;
         hist_l_in = '0;
         hist_r_in = '0;
         start_in  = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               n_in   = '0;
               if (start_ff) begin
                  phase_in = {1'b0, step_ff};
                  start_in = 1'b0;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (n_ff < MaxInterp && phase_ff < PhaseOne) begin
               prod_l_in = diff_l * frac;
               prod_r_in = diff_r * frac;
               state_in  = ST_EMIT;
            end else begin
               phase_in  = (phase_ff >= PhaseOne) ? phase_ff - PhaseOne : '0;
               hist_l_in = cur_ff.sample_left;
               hist_r_in = cur_ff.sample_right;
               state_in  = cur_ff.block_end ? ST_LAST : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = {sum_r[23:0], sum_l[23:0]};
               out_last_in  = 1'b0;
               n_in         = n_ff + 1'b1;
               phase_in     = phase_ff + {1'b0, step_ff};
               state_in     = ST_CHECK;
            end
         end
         ST_LAST: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_data_in  = {cur_ff.sample_right, cur_ff.sample_left};
               out_last_in  = 1'b1;
               start_in     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= StepReset;
         phase_ff     <= '0;
         n_ff         <= '0;
         start_ff     <= 1'b1;
         hist_l_ff    <= '0;
         hist_r_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         n_ff         <= n_in;
         start_ff     <= start_in;
         hist_l_ff    <= hist_l_in;
         hist_r_ff    <= hist_r_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff      <= cur_in;
      prod_l_ff   <= prod_l_in;
      prod_r_ff   <= prod_r_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   // Never more interpolated outputs per input than the cap.
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      n_ff <= MaxInterp)
      else $error("interpolation count above cap");

   // Products are formed only for positions inside the interval.
   a_emit_phase: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> phase_ff < PhaseOne)
      else $error("emit with position at or beyond one");

   // Queue is drained only between inputs.
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE && q_valid)
      else $error("queue popped outside idle");

   // Final copy of a block rearms the position load.
   a_last_rearm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAST && out_free) |=> start_ff && rsp_tlast && rsp_tvalid)
      else $error("block end did not rearm start");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the stereo linear interpolation resampler.
`timescale 1ns / 1ps

module tb_top
   import lir_pkg::*;
();

   localparam int HalfPeriod     = 10;
   localparam int ResetCycles    = 8;
   // Covers a queue of two plus the input in the engine.
   localparam int DrainCycles    = 160;
   localparam int HoldCycles     = 300;
   localparam int WatchdogLimit  = 3000;
   localparam int ReportLimit    = 10;
   localparam int RandomPhases   = 5;
   localparam int ItemsPerPhase  = 30;

   typedef enum logic {ROW_STEP, ROW_SAMPLE} row_kind_type;

   // One output sample pair, as carried on the result channel.
   typedef struct packed {
      logic                   last;
      logic [SampleWidth-1:0] right;
      logic [SampleWidth-1:0] left;
   } pair_out_type;

   // One row of the directed table. n_typed < 0: take the expectation from
   // the interpolation model instead of the typed values.
   typedef struct {
      row_kind_type           kind;
      logic [StepWidth-1:0]   step;
      logic [SampleWidth-1:0] left;
      logic [SampleWidth-1:0] right;
      logic                   last;
      int                     n_typed;
      pair_out_type [1:0]     typed;
   } stim_row_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_wr_en;
   logic [StepWidth-1:0]   csr_wr_data;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [47:0]            req_tdata;   // [23:0] sample_left, [47:24] sample_right
   logic                   req_tlast;   // block_end
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [47:0]            rsp_tdata;   // [23:0] out_left, [47:24] out_right
   logic                   rsp_tlast;   // out_last

   // Interpolation model state.
   logic [StepWidth-1:0]          step_q;
   logic signed [SampleWidth-1:0] hist_left;
   logic signed [SampleWidth-1:0] hist_right;
   logic [PhaseWidth-1:0]         phase_q;
   logic                          new_block;

   pair_out_type expected_pairs[$];
   stim_row_type directed[$];
   int           fault_count;
   int           idle_cycles;
   bit           calm;       // no idling on either side
   bit           hold_rsp;   // request one long receiver hold-off

   linear_interp_resampler_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #HalfPeriod;
      clock = 1'b0;
      #HalfPeriod;
   end

   // ---------------------------------------------------------------------
   // Interpolation model
   // ---------------------------------------------------------------------

   // a + floor(frac * (b - a) / 2^16), kept to 24 bits.
   function automatic logic [SampleWidth-1:0] lerp_sample(
      logic signed [SampleWidth-1:0] a,
      logic signed [SampleWidth-1:0] b,
      logic [PhaseWidth-1:0]         frac
   );
      longint diff;
      longint prod;
      diff = longint'(b) - longint'(a);
      prod = diff * longint'(frac);
      return SampleWidth'(longint'(a) + (prod >>> FracWidth));
   endfunction

   // Advance the model by one input transaction; record the outputs it
   // causes unless the caller supplies typed ones.
   task automatic resample_pair(
      logic [SampleWidth-1:0] left,
      logic [SampleWidth-1:0] right,
      logic                   last,
      bit                     record
   );
      int           made;
      pair_out_type pair;
      made = 0;
      if (new_block) begin
         phase_q   = PhaseWidth'(step_q);
         new_block = 1'b0;
      end
      while (made < int'(MaxInterp) && phase_q < PhaseOne) begin
         pair.left  = lerp_sample(hist_left, left, phase_q);
         pair.right = lerp_sample(hist_right, right, phase_q);
         pair.last  = 1'b0;
         if (record)
            expected_pairs.push_back(pair);
         made++;
         phase_q = phase_q + PhaseWidth'(step_q);
      end
      // Step too small to reach 1.0 within sixteen outputs: restart at zero.
      if (phase_q >= PhaseOne)
         phase_q = phase_q - PhaseOne;
      else
         phase_q = '0;
      hist_left  = left;
      hist_right = right;
      if (last) begin
         pair.left  = left;
         pair.right = right;
         pair.last  = 1'b1;
         if (record)
            expected_pairs.push_back(pair);
         new_block = 1'b1;
      end
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic stim_row_type step_row(logic [StepWidth-1:0] step);
      stim_row_type row;
      row         = '{kind: ROW_STEP, default: '0};
      row.step    = step;
      row.n_typed = -1;
      return row;
   endfunction

   function automatic stim_row_type sample_row(
      logic [SampleWidth-1:0] left,
      logic [SampleWidth-1:0] right,
      logic                   last,
      int                     n_typed = -1,
      pair_out_type           first   = '0,
      pair_out_type           second  = '0
   );
      stim_row_type row;
      row          = '{kind: ROW_SAMPLE, default: '0};
      row.left     = left;
      row.right    = right;
      row.last     = last;
      row.n_typed  = n_typed;
      row.typed[0] = first;
      row.typed[1] = second;
      return row;
   endfunction

   function automatic logic [SampleWidth-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return SampleWidth'($urandom_range(0, 64)) - 24'd32;
         default: return SampleWidth'($urandom());
      endcase
   endfunction

   function automatic logic [StepWidth-1:0] pick_step();
      case ($urandom_range(0, 9))
         0: return StepWidth'($urandom_range(0, 4095));
         1, 2: return StepWidth'($urandom_range(32'h30000, 32'hFFFFF));
         default: return StepWidth'($urandom_range(4096, 32'h30000));
      endcase
   endfunction

   // Drop tvalid for a pause whose length is given by n.
   task automatic pause_req(int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
   endtask

   // Offer one transaction and hold it until it is accepted.
   task automatic send_pair(
      logic [SampleWidth-1:0] left,
      logic [SampleWidth-1:0] right,
      logic                   last
   );
      if (!calm && $urandom_range(0, 4) == 0)
         pause_req($urandom_range(1, 13));
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {right, left};
      req_tlast  <= last;
      do
         @(posedge clock);
      while (!req_tready);
   endtask

   // Wait for the block to go idle, then write the step register.
   task automatic program_step(logic [StepWidth-1:0] step);
      pause_req(1);
      while (expected_pairs.size() != 0)
         @(posedge clock);
      // An input that makes no output may still be in the engine.
      repeat (DrainCycles) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= step;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      step_q     = step;
      hist_left  = '0;
      hist_right = '0;
      new_block  = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      int                     left_in_block;
      logic [SampleWidth-1:0] left;
      logic [SampleWidth-1:0] right;
      logic                   last;

      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      calm        = 1'b0;
      hold_rsp    = 1'b0;
      step_q      = StepReset;
      hist_left   = '0;
      hist_right  = '0;
      phase_q     = '0;
      new_block   = 1'b1;

      // Step 1.0 after reset: each output repeats the previous input.
      directed.push_back(sample_row(24'h7FFFFF, 24'h800000, 1'b0, 0));
      directed.push_back(sample_row(24'h800000, 24'h7FFFFF, 1'b0, 1,
         '{left: 24'h7FFFFF, right: 24'h800000, last: 1'b0}));
      directed.push_back(sample_row(24'h123456, 24'hFEDCBA, 1'b1, 2,
         '{left: 24'h800000, right: 24'h7FFFFF, last: 1'b0},
         '{left: 24'h123456, right: 24'hFEDCBA, last: 1'b1}));
      // Block of one input: only the final copy.
      directed.push_back(sample_row(24'h000005, 24'hFFFFFB, 1'b1, 1,
         '{left: 24'h000005, right: 24'hFFFFFB, last: 1'b1}));
      // Half step, with negative differences to exercise the truncation.
      directed.push_back(step_row(20'h08000));
      directed.push_back(sample_row(24'h400000, 24'hC00000, 1'b0));
      directed.push_back(sample_row(24'hFFFFFF, 24'h000001, 1'b0));
      directed.push_back(sample_row(24'h000007, 24'hFFFFF9, 1'b1));
      // Smallest step in range: fifteen outputs for the first input, then sixteen.
      directed.push_back(step_row(20'h01000));
      directed.push_back(sample_row(24'h7FFFFF, 24'h800000, 1'b0));
      directed.push_back(sample_row(24'h800000, 24'h7FFFFF, 1'b1));
      // Zero step: sixteen copies of the history, never a stall.
      directed.push_back(step_row(20'h00000));
      directed.push_back(sample_row(24'h000064, 24'hFFFF9C, 1'b0));
      directed.push_back(sample_row(24'h000003, 24'h000004, 1'b1));
      // Below range: sixteen outputs, then the position restarts at zero.
      directed.push_back(step_row(20'd1000));
      directed.push_back(sample_row(24'h2AAAAA, 24'hD55555, 1'b0));
      directed.push_back(sample_row(24'h555555, 24'hAAAAAA, 1'b1));
      // Largest step: inputs with no position in their interval.
      directed.push_back(step_row(20'hFFFFF));
      directed.push_back(sample_row(24'h000001, 24'h000002, 1'b0, 0));
      directed.push_back(sample_row(24'h7FFFFF, 24'h7FFFFF, 1'b0, 0));
      directed.push_back(sample_row(24'h800000, 24'h800000, 1'b1, 1,
         '{left: 24'h800000, right: 24'h800000, last: 1'b1}));
      // Step of 1.5: some intervals hold a position, some do not.
      directed.push_back(step_row(20'h18000));
      directed.push_back(sample_row(24'h100000, 24'hF00000, 1'b0));
      directed.push_back(sample_row(24'hF00000, 24'h100000, 1'b0));
      directed.push_back(sample_row(24'h0ABCDE, 24'hF54321, 1'b0));
      directed.push_back(sample_row(24'h7FFFFF, 24'h800000, 1'b1));

      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_STEP) begin
            program_step(directed[i].step);
         end else begin
            send_pair(directed[i].left, directed[i].right, directed[i].last);
            resample_pair(directed[i].left, directed[i].right, directed[i].last,
               directed[i].n_typed < 0);
            for (int k = 0; k < directed[i].n_typed; k++)
               expected_pairs.push_back(directed[i].typed[k]);
         end
      end

      // Random phases: random step, random blocks, random content.
      for (int ph = 0; ph < RandomPhases; ph++) begin
         program_step(ph == 0 ? 20'h08000 : pick_step());
         // Hold the receiver off while inputs keep coming, so the block fills.
         if (ph == 0)
            hold_rsp = 1'b1;
         // Run the last phase with no idling at all.
         calm = (ph == RandomPhases - 1);
         left_in_block = 0;
         for (int i = 0; i < ItemsPerPhase; i++) begin
            if (left_in_block == 0)
               left_in_block = $urandom_range(1, 12);
            left_in_block--;
            left  = pick_sample();
            right = pick_sample();
            last  = (left_in_block == 0);
            send_pair(left, right, last);
            resample_pair(left, right, last, 1'b1);
         end
      end

      pause_req(1);
      while (expected_pairs.size() != 0)
         @(posedge clock);
      // Leave time for any stray output after the last expected one.
      repeat (DrainCycles) @(posedge clock);
      if (fault_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: random back-pressure plus one long hold-off
   // ---------------------------------------------------------------------

   initial begin
      int stall;
      stall      = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            stall    = HoldCycles;
         end else if (!calm && stall == 0 && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 13);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      pair_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pairs.size() == 0) begin
            fault_count++;
            if (fault_count <= ReportLimit)
               $display("unexpected result: l=%h r=%h last=%b",
                  rsp_tdata[23:0], rsp_tdata[47:24], rsp_tlast);
         end else begin
            want = expected_pairs.pop_front();
            if (rsp_tdata[23:0] !== want.left || rsp_tdata[47:24] !== want.right ||
                rsp_tlast !== want.last) begin
               fault_count++;
               if (fault_count <= ReportLimit)
                  $display("mismatch: expected l=%h r=%h last=%b, got l=%h r=%h last=%b",
                     want.left, want.right, want.last,
                     rsp_tdata[23:0], rsp_tdata[47:24], rsp_tlast);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: end the run if no transaction moves for too long
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

endmodule
